[src/lfu_pkg.sv]
// Shared constants and control types for the LFU cache with LRU tie-break.
package lfu_pkg;

    // Default number of table entries
    localparam int CAP_DEF = 16;

    // Payload widths
    localparam int DATA_W = 32;
    localparam int CNT_W  = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration port
    localparam int APB_W  = 32;
    localparam int PADDR_W = 3;
    localparam int CFG_W  = 5;
    localparam logic [CFG_W-1:0] CFG_CAPACITY_RST = 5'd16;

    // Register index (byte address / 4)
    localparam logic REG_CAPACITY = 1'b0;

    // Operation codes
    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic start;    // latch request word, clear scan results
        logic scan_rd;  // read entry at addr for the lookup pass
        logic decide;   // register the outcome of the lookup pass
        logic upd_rd;   // read entry at addr for the rank update pass
        logic commit;   // write entry fields, valid bits and response word
    } cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic upd_needed;  // ranks change, run the update pass
    } sts_t;

endpackage

[src/lfu_if.sv]
// Request and response channel interfaces of the LFU cache.
interface lfu_req_if import lfu_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     mode;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, mode, key, value, input ready);
    modport sink   (input valid, mode, key, value, output ready);
endinterface

interface lfu_rsp_if import lfu_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
    logic                     evicted;

    modport source (output valid, hit, read_value, evicted, input ready);
    modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

[src/lfu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lfu_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/lfu_ctrl.sv]
// Sequencer: steps the lookup pass, the rank update pass and the commit.
module lfu_ctrl import lfu_pkg::*; #(
    parameter int CAP = CAP_DEF,
    localparam int IW = (CAP > 1) ? $clog2(CAP) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output cmd_t          cmd,
    output logic [IW-1:0] addr,
    input  sts_t          sts
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_SDRAIN = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_UPDATE = 7'b0010000,
        S_UDRAIN = 7'b0100000,
        S_COMMIT = 7'b1000000
    } state_t;

    state_t        state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          rsp_valid_reg, rsp_valid_next;
    logic          idx_last;
    logic          out_free;

    assign idx_last  = (idx_reg == IW'(CAP - 1));
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign addr      = idx_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start  = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_SDRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_SDRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = sts.upd_needed ? S_UPDATE : S_COMMIT;
            end
            S_UPDATE:
            begin
                cmd.upd_rd = 1'b1;
                if (idx_last)
                begin
                    idx_next   = '0;
                    state_next = S_UDRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_UDRAIN:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                // hold until the response register is free
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

[src/lfu_dp.sv]
// Datapath: entry RAMs, valid bits, lookup/victim search, rank update and response word.
module lfu_dp import lfu_pkg::*; #(
    parameter int CAP = CAP_DEF,
    localparam int IW = (CAP > 1) ? $clog2(CAP) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic [IW-1:0]            addr,
    output sts_t                     sts,
    input  logic [CFG_W-1:0]         capacity,
    input  logic                     req_mode,
    input  logic [DATA_W-1:0]        req_key,
    input  logic [DATA_W-1:0]        req_value,
    output logic                     rsp_hit,
    output logic signed [DATA_W-1:0] rsp_read_value,
    output logic                     rsp_evicted
);

    localparam int RW  = IW;
    localparam int HW  = $clog2(CAP + 1);
    localparam int CMW = (HW > CFG_W) ? HW : CFG_W;

    // Request word
    logic              mode_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;

    // Read pipeline: entry index whose RAM data is on the read ports
    logic          ev_vld_reg;
    logic          up_vld_reg;
    logic [IW-1:0] pidx_reg;

    // Lookup pass results
    logic             found_reg;
    logic [IW-1:0]    found_idx_reg;
    logic [RW-1:0]    found_rank_reg;
    logic [CNT_W-1:0] found_cnt_reg;
    logic [DATA_W-1:0] found_val_reg;
    logic [HW-1:0]    held_reg;
    logic             vic_ok_reg;
    logic [IW-1:0]    vic_idx_reg;
    logic [CNT_W-1:0] vic_cnt_reg;
    logic [RW-1:0]    vic_rank_reg;
    logic             free_ok_reg;
    logic [IW-1:0]    free_idx_reg;

    // Decision
    logic          touch_reg;
    logic          insert_reg;
    logic          evict_reg;
    logic          wval_reg;
    logic [IW-1:0] tgt_reg;
    logic [RW-1:0] ref_reg;

    logic [CAP-1:0] valid_reg;
    logic [CAP-1:0] valid_next;

    // Response word
    logic              hit_reg;
    logic [DATA_W-1:0] rd_reg;
    logic              evd_reg;

    // RAM ports
    logic [DATA_W-1:0] key_rd;
    logic [DATA_W-1:0] val_rd;
    logic [CNT_W-1:0]  cnt_rd;
    logic [RW-1:0]     rank_rd;
    logic              rank_we;
    logic [RW-1:0]     rank_wd;
    logic [CNT_W-1:0]  cnt_wd;

    // Per-entry evaluation
    logic cur_v;
    logic key_match;
    logic take_vic;

    // Decision logic
    logic [CMW-1:0] cap_wide;
    logic [CMW-1:0] cap_eff;
    logic           cap_zero;
    logic           d_touch;
    logic           d_insert;
    logic           d_evict;
    logic [IW-1:0]  d_slot;
    logic [IW-1:0]  d_tgt;

    // Update pass
    logic u_tgt;
    logic u_inc;

    // ---------------- entry RAMs ----------------
    lfu_ram #(.W(DATA_W), .DEPTH(CAP)) u_key_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && insert_reg),
        .wr_addr (tgt_reg),
        .wr_data (key_reg),
        .rd_en   (cmd.scan_rd),
        .rd_addr (addr),
        .rd_data (key_rd)
    );

    lfu_ram #(.W(DATA_W), .DEPTH(CAP)) u_val_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && wval_reg),
        .wr_addr (tgt_reg),
        .wr_data (value_reg),
        .rd_en   (cmd.scan_rd),
        .rd_addr (addr),
        .rd_data (val_rd)
    );

    lfu_ram #(.W(CNT_W), .DEPTH(CAP)) u_cnt_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && (touch_reg || insert_reg)),
        .wr_addr (tgt_reg),
        .wr_data (cnt_wd),
        .rd_en   (cmd.scan_rd),
        .rd_addr (addr),
        .rd_data (cnt_rd)
    );

    lfu_ram #(.W(RW), .DEPTH(CAP)) u_rank_ram (
        .clk     (clk),
        .wr_en   (rank_we),
        .wr_addr (pidx_reg),
        .wr_data (rank_wd),
        .rd_en   (cmd.scan_rd || cmd.upd_rd),
        .rd_addr (addr),
        .rd_data (rank_rd)
    );

    // ---------------- read pipeline ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_vld_reg <= 1'b0;
            up_vld_reg <= 1'b0;
        end
        else
        begin
            ev_vld_reg <= cmd.scan_rd;
            up_vld_reg <= cmd.upd_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= addr;
    end

    // ---------------- lookup pass ----------------
    assign cur_v     = valid_reg[pidx_reg];
    assign key_match = cur_v && (key_rd == key_reg);
    // lowest count wins, least recent (highest rank) breaks ties
    assign take_vic  = cur_v && (!vic_ok_reg || (cnt_rd < vic_cnt_reg)
                       || ((cnt_rd == vic_cnt_reg) && (rank_rd > vic_rank_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg   <= 1'b0;
            held_reg    <= '0;
            vic_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            found_reg   <= 1'b0;
            held_reg    <= '0;
            vic_ok_reg  <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else if (ev_vld_reg)
        begin
            if (cur_v)
            begin
                held_reg <= held_reg + HW'(1);
            end
            if (key_match)
            begin
                found_reg <= 1'b1;
            end
            if (take_vic)
            begin
                vic_ok_reg <= 1'b1;
            end
            if (!cur_v)
            begin
                free_ok_reg <= 1'b1;
            end
        end
    end

    // Request word and captured entry fields
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg  <= req_mode;
            key_reg   <= req_key;
            value_reg <= req_value;
        end
        if (ev_vld_reg)
        begin
            if (key_match && !found_reg)
            begin
                found_idx_reg  <= pidx_reg;
                found_rank_reg <= rank_rd;
                found_cnt_reg  <= cnt_rd;
                found_val_reg  <= val_rd;
            end
            if (take_vic)
            begin
                vic_idx_reg  <= pidx_reg;
                vic_cnt_reg  <= cnt_rd;
                vic_rank_reg <= rank_rd;
            end
            if (!cur_v && !free_ok_reg)
            begin
                free_idx_reg <= pidx_reg;
            end
        end
    end

    // ---------------- decision ----------------
    assign cap_wide = CMW'(capacity);
    assign cap_eff  = (cap_wide > CMW'(CAP)) ? CMW'(CAP) : cap_wide;
    assign cap_zero = (capacity == '0);
    assign d_touch  = found_reg && ((mode_reg == MODE_GET) || !cap_zero);
    assign d_insert = (mode_reg == MODE_PUT) && !cap_zero && !found_reg;
    assign d_evict  = d_insert && (CMW'(held_reg) >= cap_eff);
    // first free slot once the victim is gone
    assign d_slot   = (d_evict && !(free_ok_reg && (free_idx_reg < vic_idx_reg)))
                      ? vic_idx_reg : free_idx_reg;
    assign d_tgt    = found_reg ? found_idx_reg : d_slot;

    assign sts.upd_needed = d_touch || d_insert;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_reg  <= 1'b0;
            insert_reg <= 1'b0;
            evict_reg  <= 1'b0;
            wval_reg   <= 1'b0;
        end
        else if (cmd.decide)
        begin
            touch_reg  <= d_touch;
            insert_reg <= d_insert;
            evict_reg  <= d_evict;
            wval_reg   <= d_insert || (d_touch && (mode_reg == MODE_PUT));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decide)
        begin
            tgt_reg <= d_tgt;
            ref_reg <= found_reg ? found_rank_reg : vic_rank_reg;
        end
    end

    // ---------------- rank update pass ----------------
    // target becomes newest; others age by one if newer than ref or on free-slot insert
    assign u_tgt   = (pidx_reg == tgt_reg);
    assign u_inc   = cur_v && !(evict_reg && (pidx_reg == vic_idx_reg))
                     && ((insert_reg && !evict_reg) || (rank_rd < ref_reg));
    assign rank_we = up_vld_reg && (u_tgt || u_inc);
    assign rank_wd = u_tgt ? '0 : rank_rd + RW'(1);

    // ---------------- commit ----------------
    assign cnt_wd = insert_reg ? CNT_W'(1)
                  : ((found_cnt_reg == CNT_MAX) ? CNT_MAX : found_cnt_reg + CNT_W'(1));

    // victim drops out first; the new entry may reuse its slot
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.commit && evict_reg)
        begin
            valid_next[vic_idx_reg] = 1'b0;
        end
        if (cmd.commit && insert_reg)
        begin
            valid_next[tgt_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Response word
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg <= found_reg;
            evd_reg <= evict_reg;
            if (mode_reg == MODE_GET)
            begin
                rd_reg <= found_reg ? found_val_reg : '1;
            end
            else
            begin
                rd_reg <= '0;
            end
        end
    end

    assign rsp_hit        = hit_reg;
    assign rsp_read_value = rd_reg;
    assign rsp_evicted    = evd_reg;

endmodule

[src/lfu_cache_replacement.sv]
// Top level of the LFU cache with LRU tie-break: config register, sequencer and datapath.
//
//  channel   dir  handshake               word
//  req       in   req.valid / req.ready   mode, key, value
//  rsp       out  rsp.valid / rsp.ready   hit, read_value, evicted
//  apb       in   psel, penable, pready   paddr, pwrite, pwdata -> prdata
//
//  One operation at a time. A touch or an insert runs a lookup pass and a rank
//  update pass, each one entry per cycle through the single read port of the
//  entry RAMs. A get miss or a put at capacity zero skips the update pass.
//  Reset clears the valid bits at once; there is no clearing pass.
//  The response waits in an output register; the next request is accepted
//  meanwhile and holds in its commit cycle until that register is taken.
module lfu_cache_replacement import lfu_pkg::*; #(
    parameter int CAP = CAP_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    lfu_req_if.sink            req,
    lfu_rsp_if.source          rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;

    logic [CFG_W-1:0] capacity_reg;
    logic             reg_idx;
    cmd_t             cmd;
    sts_t             sts;
    logic [IW-1:0]    addr;

    // APB register
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CFG_CAPACITY_RST;
        end
        else if (psel && penable && pwrite && pready && (reg_idx == REG_CAPACITY))
        begin
            capacity_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CAPACITY: prdata = APB_W'(capacity_reg);
            default:      prdata = '0;
        endcase
    end

    // Sequencer
    lfu_ctrl #(.CAP(CAP)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .addr      (addr),
        .sts       (sts)
    );

    // Datapath
    lfu_dp #(.CAP(CAP)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .addr           (addr),
        .sts            (sts),
        .capacity       (capacity_reg),
        .req_mode       (req.mode),
        .req_key        (req.key),
        .req_value      (req.value),
        .rsp_hit        (rsp.hit),
        .rsp_read_value (rsp.read_value),
        .rsp_evicted    (rsp.evicted)
    );

endmodule

[src/lfu_chk.sv]
// Port-level checker for the LFU cache, bound to the top level.
module lfu_chk import lfu_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic              rsp_hit,
    input logic [DATA_W-1:0] rsp_read_value,
    input logic              rsp_evicted
);

    // Stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
        && $stable(rsp_hit) && $stable(rsp_read_value) && $stable(rsp_evicted))
        else $error("response word changed while stalled");

    // One operation at a time: busy right after a request is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an operation is in flight");

    // An eviction only comes from a put of a new key
    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_evicted |-> !rsp_hit && (rsp_read_value == '0))
        else $error("eviction reported on a hit or a get");

    // A miss reads all ones (get) or zero (put), nothing else
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_hit && (rsp_read_value != '0)
        |-> (rsp_read_value == '1) && !rsp_evicted)
        else $error("miss returned a stored value");

endmodule

bind lfu_cache_replacement lfu_chk u_lfu_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_hit        (rsp.hit),
    .rsp_read_value (rsp.read_value),
    .rsp_evicted    (rsp.evicted)
);
